// ----- design/oblivious_min_priority_queue_core_defines.svh -----
// Assertion macros shared by the priority queue RTL.
// Depends on clk and rst_n being visible in the including module.
`ifndef OBLIVIOUS_MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define OBLIVIOUS_MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OMPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ompq assertion failed");

// Next-cycle implication, checked outside reset.
`define OMPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ompq assertion failed");

`endif

// ----- design/ompq_pkg.sv -----
// Shared types and codes for the linear-scan minimum priority queue.
// No dependencies.
package ompq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2
    } cmd_t;

    // One stored entry: signed Q16.16 distance and identifier.
    typedef struct packed {
        logic signed [31:0] distance;
        logic [30:0]        id;
    } entry_t;

endpackage

// ----- design/ompq_store.sv -----
// Entry store: single-port-write, single-port-read synchronous RAM.
// Depends on ompq_pkg for the entry type. Read data appears the cycle after rd_en.
module ompq_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  ompq_pkg::entry_t wr_entry,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output ompq_pkg::entry_t rd_entry
);

    ompq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry <= mem[rd_addr];
        end
    end

endmodule

// ----- design/oblivious_min_priority_queue_core.sv -----
// Top level of the linear-scan minimum priority queue.
// Depends on ompq_pkg, ompq_store and oblivious_min_priority_queue_core_defines.svh.
//
// Usage:
//   s_* channel carries commands: insert, pop minimum, peek minimum. Every
//   command transaction yields exactly one result transaction on m_*.
//   Insert writes the entry at slot count and reports overflow
//   when the store is already full. Pop and peek stream slots 0..count-1 out
//   of the entry RAM, one slot per cycle, and keep the first smallest signed
//   distance. Pop then reads the last slot and writes it over the winner.
// Timing: insert, an unused command or an empty store goes straight to the
//   result; peek scans every stored slot, and pop also reads the last slot
//   and writes it back. The scan over the RAM read port sets the worst case.
// Throughput: one command at a time; s_tready is high only while idle, and the
//   core returns to idle when the previous result is registered.
// Results sit in an output register: a stalled receiver holds m_tvalid and
//   m_tdata, and the core may accept and work the next command meanwhile; it
//   waits only when that next result is ready and the register is still full.
// Reset clears the count, the control state and m_tvalid. The entry RAM is
//   not cleared: only slots below the count are ever read.
// Slot accesses never overlap: each write lands in a cycle with no read in
//   flight, so no forwarding is required.
module oblivious_min_priority_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] cmd, [33:2] entry_dist, [64:34] entry_id, [71:65] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] found, [32:1] least_dist, [63:33] min_id, [70:64] entry_count, [71] overflow
    output logic [71:0] m_tdata
);

`include "oblivious_min_priority_queue_core_defines.svh"

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic          first_reg, first_next;
    logic          pop_reg, pop_next;
    logic signed [31:0] best_dist_reg, best_dist_next;
    logic [30:0]   best_id_reg, best_id_next;
    logic          res_found_reg, res_found_next;
    logic signed [31:0] res_dist_reg, res_dist_next;
    logic [30:0]   res_id_reg, res_id_next;
    logic          res_ovf_reg, res_ovf_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [71:0]   m_tdata_reg, m_tdata_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    ompq_pkg::entry_t wr_entry;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    ompq_pkg::entry_t rd_entry;

    ompq_pkg::cmd_t   in_cmd;
    logic             take;

    assign in_cmd   = ompq_pkg::cmd_t'(s_tdata[1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ompq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    // Keep the first smallest: replace only on strictly smaller distance.
    assign take = first_reg || (rd_entry.distance < best_dist_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        best_idx_next  = best_idx_reg;
        first_next     = first_reg;
        pop_next       = pop_reg;
        best_dist_next = best_dist_reg;
        best_id_next   = best_id_reg;
        res_found_next = res_found_reg;
        res_dist_next  = res_dist_reg;
        res_id_next    = res_id_reg;
        res_ovf_next   = res_ovf_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_entry.distance = s_tdata[33:2];
        wr_entry.id    = s_tdata[64:34];
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_found_next = 1'b0;
                    res_dist_next  = '0;
                    res_id_next    = '0;
                    res_ovf_next   = 1'b0;
                    state_next     = ST_EMIT;
                    case (in_cmd)
                        ompq_pkg::CMD_INSERT:
                        begin
                            // Append at the fill point, or drop and flag overflow.
                            if (count_reg < CW'(CAPACITY))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                res_ovf_next = 1'b1;
                            end
                        end
                        ompq_pkg::CMD_POP,
                        ompq_pkg::CMD_PEEK:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en        = 1'b1;
                                rd_addr      = '0;
                                cmp_idx_next = '0;
                                issue_next   = CW'(1);
                                first_next   = 1'b1;
                                pop_next     = (in_cmd == ompq_pkg::CMD_POP);
                                state_next   = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                first_next = 1'b0;
                if (take)
                begin
                    best_dist_next = rd_entry.distance;
                    best_id_next   = rd_entry.id;
                    best_idx_next  = cmp_idx_reg;
                end
                if (issue_reg < count_reg)
                begin
                    // Advance: fetch the next slot while comparing this one.
                    rd_en        = 1'b1;
                    rd_addr      = issue_reg[AW-1:0];
                    cmp_idx_next = issue_reg[AW-1:0];
                    issue_next   = issue_reg + CW'(1);
                end
                else
                begin
                    res_found_next = 1'b1;
                    res_dist_next  = take ? rd_entry.distance : best_dist_reg;
                    res_id_next    = take ? rd_entry.id : best_id_reg;
                    if (pop_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = ST_LAST;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LAST:
            begin
                // Move the last slot into the winner's slot and shrink.
                wr_en      = 1'b1;
                wr_addr    = best_idx_reg;
                wr_entry   = rd_entry;
                count_next = count_reg - CW'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_ovf_reg, 7'(count_reg), res_id_reg,
                                     res_dist_reg, res_found_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg     <= issue_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        first_reg     <= first_next;
        pop_reg       <= pop_next;
        best_dist_reg <= best_dist_next;
        best_id_reg   <= best_id_next;
        res_found_reg <= res_found_next;
        res_dist_reg  <= res_dist_next;
        res_id_reg    <= res_id_next;
        res_ovf_reg   <= res_ovf_next;
    end

    `OMPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `OMPQ_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN,
                     CW'(cmp_idx_reg) < count_reg && issue_reg <= count_reg)
    `OMPQ_ASSERT_NEXT(a_pop_shrinks, state_reg == ST_LAST,
                      count_reg == $past(count_reg) - CW'(1))
    `OMPQ_ASSERT_NOW(a_ovf_not_found, m_tvalid_reg && m_tdata_reg[71], !m_tdata_reg[0])

endmodule

// ----- sim/min_queue_checker.sv -----
`timescale 1ns / 1ps
// Checker for the linear-scan minimum priority queue: watches both streams,
// predicts each result from its own copy of the store and compares it.
// Depends on ompq_pkg.
module min_queue_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          pending,
    output int          failures
);

    // Same bit layout as m_tdata, overflow in the top bit.
    typedef struct packed {
        logic               overflow;
        logic [6:0]         entry_count;
        logic [30:0]        min_id;
        logic signed [31:0] least_dist;
        logic               found;
    } queue_result_t;

    logic signed [31:0] dist_mem [CAPACITY];
    logic [30:0]        id_mem   [CAPACITY];
    int                 held = 0;
    int                 errs = 0;
    queue_result_t      results_due [$];

    function automatic queue_result_t predict_queue_result(input logic [71:0] word);
        logic [1:0]    op;
        int            best;
        int            k;
        queue_result_t r;
        op = word[1:0];
        r  = '0;
        if (op == ompq_pkg::CMD_INSERT)
        begin
            if (held < CAPACITY)
            begin
                dist_mem[held] = word[33:2];
                id_mem[held]   = word[64:34];
                held++;
            end
            else
            begin
                r.overflow = 1'b1;
            end
        end
        else if ((op == ompq_pkg::CMD_POP || op == ompq_pkg::CMD_PEEK) && held > 0)
        begin
            best = 0;
            for (k = 1; k < held; k++)
            begin
                if (dist_mem[k] < dist_mem[best])
                begin
                    best = k;
                end
            end
            r.found      = 1'b1;
            r.least_dist = dist_mem[best];
            r.min_id     = id_mem[best];
            if (op == ompq_pkg::CMD_POP)
            begin
                dist_mem[best] = dist_mem[held - 1];
                id_mem[best]   = id_mem[held - 1];
                held--;
            end
        end
        r.entry_count = held[6:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        queue_result_t got;
        queue_result_t want;
        queue_result_t due;
        if (rst_n)
        begin
            // Results first: one accepted at this edge belongs to an older command.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, m_tdata);
                    errs++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("found", 32'(want.found), 32'(got.found));
                    check_field("least_dist", want.least_dist, got.least_dist);
                    check_field("min_id", 32'(want.min_id), 32'(got.min_id));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(got.entry_count));
                    check_field("overflow", 32'(want.overflow), 32'(got.overflow));
                end
            end
            if (s_tvalid && s_tready)
            begin
                due = predict_queue_result(s_tdata);
                results_due.insert(results_due.size(), due);
            end
        end
        pending  <= results_due.size();
        failures <= errs;
    end

endmodule

// ----- sim/oblivious_min_priority_queue_core_test.sv -----
`timescale 1ns / 1ps
// Testbench top for oblivious_min_priority_queue_core: drives commands and
// receiver stalls, and gives the verdict from the checker's failure count.
// Depends on ompq_pkg, min_queue_checker and the core RTL.
module oblivious_min_priority_queue_core_test;

    localparam int CAPACITY = 64;
    // cmd encoding left unused by the core; it must change nothing
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 143;
    // cycles with no transaction on either side before the run is declared hung
    localparam int STALL_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // [1:0] cmd, [33:2] entry_dist, [64:34] entry_id, [71:65] zero
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [0] found, [32:1] least_dist, [63:33] min_id, [70:64] entry_count, [71] overflow
    logic [71:0] m_tdata;

    int pending;
    int failures;
    int tx_idle_pct;
    int rx_idle_pct;
    int shadow_count;   // store occupancy as seen by the stimulus, used only to steer it
    int quiet_cycles;

    oblivious_min_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    min_queue_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .pending(pending),
        .failures(failures)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: stall at random with the current idle percentage.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run when neither side moves a transaction for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one command, with a random idle gap first; return at the edge
    // that accepts it. Valid is never dropped and raised in the same step.
    task automatic push_command(input logic [1:0] op, input logic [31:0] dist_val,
                                input logic [30:0] id);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, id, dist_val, op};
        do @(posedge clk); while (!s_tready);
        if (op == ompq_pkg::CMD_INSERT && shadow_count < CAPACITY)
        begin
            shadow_count++;
        end
        else if (op == ompq_pkg::CMD_POP && shadow_count > 0)
        begin
            shadow_count--;
        end
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [31:0] random_distance();
        logic [31:0] d;
        case ($urandom_range(3))
            0: d = int'($urandom_range(8)) - 4;    // narrow range, many ties
            1:
            begin
                case ($urandom_range(3))
                    0: d = 32'h8000_0000;
                    1: d = 32'h7FFF_FFFF;
                    2: d = 32'h0000_0000;
                    default: d = 32'hFFFF_FFFF;
                endcase
            end
            default: d = $urandom;
        endcase
        return d;
    endfunction

    function automatic logic [30:0] random_id();
        if ($urandom_range(3) == 0)
        begin
            return 31'($urandom_range(15));
        end
        return 31'($urandom);
    endfunction

    initial
    begin : stimulus
        int  phase;
        int  sent;
        int  roll;
        bit  filling;
        logic [1:0] op;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        shadow_count = 0;
        tx_idle_pct  = 26;
        rx_idle_pct  = 64;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, extreme fields, ties, unused command, pop refill.
        push_command(ompq_pkg::CMD_POP, 32'h0, 31'h0);
        push_command(ompq_pkg::CMD_PEEK, 32'h0, 31'h0);
        push_command(CMD_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        push_command(ompq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_command(ompq_pkg::CMD_INSERT, 32'h8000_0000, 31'h0);
        push_command(ompq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 31'h1);
        push_command(ompq_pkg::CMD_INSERT, 32'h0000_0000, 31'h2);
        // same minimum as an earlier slot: the lower slot must win
        push_command(ompq_pkg::CMD_INSERT, 32'h8000_0000, 31'h3);
        push_command(ompq_pkg::CMD_PEEK, 32'h0, 31'h0);
        push_command(CMD_UNUSED, 32'h0, 31'h0);
        // pop moves the last entry into the winner's slot
        push_command(ompq_pkg::CMD_POP, 32'h0, 31'h0);
        push_command(ompq_pkg::CMD_PEEK, 32'h0, 31'h0);
        push_command(ompq_pkg::CMD_INSERT, 32'h0001_0000, 31'h5555_5555);
        push_command(ompq_pkg::CMD_INSERT, 32'h0001_0000, 31'h2AAA_AAAA);
        repeat (6) push_command(ompq_pkg::CMD_POP, 32'h0, 31'h0);
        push_command(ompq_pkg::CMD_PEEK, 32'h0, 31'h0);
        wait_drained();

        // Random: alternate fill runs (up to and past full) with drain runs
        // (down to and past empty), across three idling phases.
        filling = 1'b1;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 64;
                end
                1:
                begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 26;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (sent = 0; sent < PHASE_ITEMS; sent++)
            begin
                roll = $urandom_range(99);
                if (filling)
                begin
                    if (roll < 85)      op = ompq_pkg::CMD_INSERT;
                    else if (roll < 90) op = ompq_pkg::CMD_POP;
                    else if (roll < 97) op = ompq_pkg::CMD_PEEK;
                    else                op = CMD_UNUSED;
                end
                else
                begin
                    if (roll < 80)      op = ompq_pkg::CMD_POP;
                    else if (roll < 88) op = ompq_pkg::CMD_INSERT;
                    else if (roll < 97) op = ompq_pkg::CMD_PEEK;
                    else                op = CMD_UNUSED;
                end
                push_command(op, random_distance(), random_id());
                // linger a few commands at full or empty before turning around
                if (filling && shadow_count == CAPACITY && $urandom_range(3) == 0)
                begin
                    filling = 1'b0;
                end
                else if (!filling && shadow_count == 0 && $urandom_range(2) == 0)
                begin
                    filling = 1'b1;
                end
            end
            wait_drained();
        end

        repeat (CAPACITY + 8) @(posedge clk);
        if (failures == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/ompq_pkg.sv
design/ompq_store.sv
design/oblivious_min_priority_queue_core.sv
sim/min_queue_checker.sv
sim/oblivious_min_priority_queue_core_test.sv
